[hdl/dssb_pkg.sv]
// shared types, codes and defaults for the dual stack shared buffer
package dssb_pkg;

   localparam int DEPTH_DEFAULT = 64;

   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_PEEK  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      action_type action;
      logic       stack_select;
      logic [7:0] push_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      status_type status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

[hdl/dssb_ctrl.sv]
// controller state machine: accept, execute, respond
module dssb_ctrl
   import dssb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      valid_ff;
   logic      accept;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;
   assign cmd.load  = accept;
   assign cmd.exec  = (state_ff == S_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE, S_DONE: begin
               valid_ff <= 1'b0;
               if (accept) begin
                  state_ff <= S_EXEC;
                  busy_ff  <= 1'b1;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_EXEC: begin
               state_ff <= S_DONE;
               busy_ff  <= 1'b0;
               valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && !valid_ff)
      else $error("accepted item did not raise busy");

   a_busy_then_rsp: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> valid_ff && !busy_ff)
      else $error("busy not followed by a response");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> $past(busy_ff))
      else $error("response strobe without a prior execute cycle");

endmodule

[hdl/dssb_datapath.sv]
// datapath: request register, stack counts, shared store and result registers
module dssb_datapath
   import dssb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_item,
   output rsp_type rsp_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [7:0]    mem [DEPTH];

   req_type       req_ff;
   logic [CW-1:0] low_ff, low_in;
   logic [CW-1:0] high_ff, high_in;
   logic [7:0]    rd_ff;
   logic          rd_sel_ff, rd_sel_in;
   status_type    status_ff, status_in;

   logic [CW:0]   used;
   logic          full;
   logic [CW-1:0] cnt;
   logic [CW-1:0] waddr_w, raddr_w;
   logic [AW-1:0] waddr, raddr;
   logic          wr_en;

   assign used = {1'b0, low_ff} + {1'b0, high_ff};
   assign full = (used >= (CW+1)'(DEPTH));
   assign cnt  = req_ff.stack_select ? high_ff : low_ff;

   // low stack grows up from 0, high stack down from the top
   assign waddr_w = req_ff.stack_select ? (CW'(DEPTH - 1) - high_ff) : low_ff;
   assign raddr_w = req_ff.stack_select ? (CW'(DEPTH) - high_ff) : (low_ff - CW'(1));
   assign waddr   = waddr_w[AW-1:0];
   assign raddr   = raddr_w[AW-1:0];

   always_comb begin
      low_in    = low_ff;
      high_in   = high_ff;
      status_in = ST_OK;
      rd_sel_in = 1'b0;
      wr_en     = 1'b0;
      case (req_ff.action)
         ACT_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en = 1'b1;
               if (req_ff.stack_select) high_in = high_ff + CW'(1);
               else                     low_in  = low_ff + CW'(1);
            end
         end
         ACT_POP, ACT_PEEK: begin
            if (cnt == '0) begin
               status_in = ST_EMPTY;
            end else begin
               rd_sel_in = 1'b1;
               if (req_ff.action == ACT_POP) begin
                  if (req_ff.stack_select) high_in = high_ff - CW'(1);
                  else                     low_in  = low_ff - CW'(1);
               end
            end
         end
         default: begin
            low_in  = '0;
            high_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else if (cmd.exec) begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_item;
      if (cmd.exec) begin
         status_ff <= status_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   // shared store, one registered read and at most one write per execute cycle
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) mem[waddr] <= req_ff.push_data;
      if (cmd.exec) rd_ff <= mem[raddr];
   end

   assign rsp_item.read_data = rd_sel_ff ? rd_ff : 8'd0;
   assign rsp_item.status    = status_ff;

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      used <= (CW+1)'(DEPTH))
      else $error("stack counts exceed the store");

endmodule

[hdl/dual_stack_shared_buffer.sv]
// top level of the dual stack shared buffer
//
//  channel   ports                      transfer when
//  request   start, busy, req_item      start high and busy low at a clock edge
//  response  rsp_valid, rsp_item        rsp_valid high, one cycle, cannot stall
//
// an accepted request executes in the following cycle (one store access and
// count update) and its response strobes the cycle after that
// a new request may be taken in the response cycle, so one item every two
// cycles, set by the registered read of the shared store
// reset clears both stack counts; store contents are never cleared and an
// entry is only read after a push wrote it
// the receiver cannot stall; busy is the only back pressure
module dual_stack_shared_buffer
   import dssb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   // response channel
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   // command lines from the controller to the datapath
   cmd_type cmd;

   // sequencing: accept, execute, respond
   dssb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // counts, shared store and result registers
   dssb_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule
